FILE: sv/aes_pkg.sv
// Package: AES-128 types, tables and round functions.
`default_nettype none
package aes_pkg;
    localparam int unsigned NumRounds = 10;
    localparam int unsigned BlockW    = 128;
    localparam int unsigned HalfW     = 64;

    typedef enum logic [0:0] {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } t_cmd;

    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic              vld;
        t_cmd              cmd;
        logic [BlockW-1:0] state;
        logic [BlockW-1:0] key;
    } t_cell_bus;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    // round constants, index = round - 1
    localparam logic [7:0] RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    // byte b of a packed 128-bit word
    function automatic logic [7:0] get_byte(input logic [BlockW-1:0] w, input int b);
        return w[BlockW-1-8*b -: 8];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
    endfunction

    // word w of the schedule key, rotated and substituted, plus rcon
    function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
        return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
    endfunction

    // next round key from key of round r-1 (rc = RCON[r-1])
    function automatic logic [BlockW-1:0] key_fwd(input logic [BlockW-1:0] k,
                                                   input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3;
        w0 = k[127:96] ^ sub_rot(k[31:0], rc);
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // previous round key from key of round r (rc = RCON[r-1])
    function automatic logic [BlockW-1:0] key_bwd(input logic [BlockW-1:0] k,
                                                   input logic [7:0] rc);
        logic [31:0] p1, p2, p3, p0;
        p3 = k[31:0] ^ k[63:32];
        p2 = k[63:32] ^ k[95:64];
        p1 = k[95:64] ^ k[127:96];
        p0 = k[127:96] ^ sub_rot(p3, rc);
        return {p0, p1, p2, p3};
    endfunction

    function automatic logic [BlockW-1:0] enc_round(input logic [BlockW-1:0] s,
                                                     input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [BlockW-1:0] o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[c*4+r] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
            if (last) begin
                o[BlockW-1-32*c -: 32] = {a0, a1, a2, a3};
            end else begin
                o[BlockW-1-32*c -: 32] = {
                    xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                    a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                    a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                    xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
            end
        end
        return o;
    endfunction

    // inverse shift rows then inverse sub bytes
    function automatic logic [BlockW-1:0] dec_sub_shift(input logic [BlockW-1:0] s);
        logic [BlockW-1:0] o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o[BlockW-1-8*(((c + r) % 4) * 4 + r) -: 8] = INV_SBOX[get_byte(s, c*4+r)];
            end
        end
        return o;
    endfunction

    function automatic logic [BlockW-1:0] inv_mix(input logic [BlockW-1:0] s);
        logic [7:0] a [4];
        logic [7:0] a2 [4];
        logic [7:0] a4 [4];
        logic [7:0] a8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [BlockW-1:0] o;
        o = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]  = get_byte(s, c*4+k);
                a2[k] = xt(a[k]);
                a4[k] = xt(a2[k]);
                a8[k] = xt(a4[k]);
                m9[k] = a8[k] ^ a[k];
                mb[k] = a8[k] ^ a2[k] ^ a[k];
                md[k] = a8[k] ^ a4[k] ^ a[k];
                me[k] = a8[k] ^ a4[k] ^ a2[k];
            end
            o[BlockW-1-32*c -: 32] = {
                me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
        end
        return o;
    endfunction
endpackage
`default_nettype wire

FILE: sv/aes_if.sv
// Interfaces: input block, result and configuration write channels.
`default_nettype none
interface aes_in_if;
    import aes_pkg::*;
    logic        valid;
    logic        ready;
    logic [0:0]  cmd;
    logic [63:0] block_high;
    logic [63:0] block_low;
    modport source (output valid, cmd, block_high, block_low, input ready);
    modport sink   (input valid, cmd, block_high, block_low, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/aes_key_cell.sv
// Key prep cell: one backward-free forward key expansion step for decrypt setup.
`default_nettype none
module aes_key_cell
    import aes_pkg::*;
#(
    parameter int unsigned STEP = 1
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_adv,
    input  wire t_cell_bus i_bus,
    output t_cell_bus      o_bus
);
    t_cell_bus r_bus;
    t_cell_bus n_bus;

    // decrypt items walk the key up to round ten; encrypt items pass unchanged
    always_comb begin
        n_bus = i_bus;
        if (i_bus.cmd == CMD_DECRYPT) begin
            n_bus.key = key_fwd(i_bus.key, RCON[STEP-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.vld <= 1'b0;
        end else if (i_adv) begin
            r_bus.vld <= n_bus.vld;
        end
        if (i_adv) begin
            r_bus.cmd   <= n_bus.cmd;
            r_bus.state <= n_bus.state;
            r_bus.key   <= n_bus.key;
        end
    end

    assign o_bus = r_bus;
endmodule
`default_nettype wire

FILE: sv/aes_round_cell.sv
// Round cell: one cipher round and one key schedule step, either direction.
`default_nettype none
module aes_round_cell
    import aes_pkg::*;
#(
    parameter int unsigned ROUND = 1
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_adv,
    input  wire t_cell_bus i_bus,
    output t_cell_bus      o_bus
);
    localparam logic       LAST = (ROUND == NumRounds);
    localparam int unsigned DecRk = NumRounds - ROUND; // round key used on decrypt

    t_cell_bus r_bus;
    t_cell_bus n_bus;
    logic [BlockW-1:0] enc_key;
    logic [BlockW-1:0] dec_key;
    logic [BlockW-1:0] dec_s;

    always_comb begin
        n_bus   = i_bus;
        enc_key = key_fwd(i_bus.key, RCON[ROUND-1]);
        // key of round DecRk from key of round DecRk+1
        dec_key = key_bwd(i_bus.key, RCON[DecRk]);
        dec_s   = dec_sub_shift(i_bus.state) ^ dec_key;
        if (i_bus.cmd == CMD_DECRYPT) begin
            n_bus.key   = dec_key;
            n_bus.state = LAST ? dec_s : inv_mix(dec_s);
        end else begin
            n_bus.key   = enc_key;
            n_bus.state = enc_round(i_bus.state, LAST) ^ enc_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus.vld <= 1'b0;
        end else if (i_adv) begin
            r_bus.vld <= n_bus.vld;
        end
        if (i_adv) begin
            r_bus.cmd   <= n_bus.cmd;
            r_bus.state <= n_bus.state;
            r_bus.key   <= n_bus.key;
        end
    end

    assign o_bus = r_bus;
endmodule
`default_nettype wire

FILE: sv/aes128_block_cipher_unit.sv
// Top level: AES-128 encrypt/decrypt as a chain of pipelined round cells.
// Stages from input transfer to result valid: one input stage, 10 key prep
// cells, then 10 round cells, whether the item encrypts or decrypts.
// Throughput: one block per cycle unless stalled, set by one round per cell.
// The whole chain stalls together when the result is not taken.
// Reset (synchronous, active low) clears all valid bits and both key registers.
`default_nettype none
module aes128_block_cipher_unit
    import aes_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    aes_in_if.sink   i_in,
    aes_out_if.source o_out,
    aes_cfg_if.sink  i_cfg
);
    logic [HalfW-1:0] r_key_high;
    logic [HalfW-1:0] r_key_low;
    logic             adv;

    t_cell_bus r_in;
    t_cell_bus n_in;
    t_cell_bus prep_bus [NumRounds+1];
    t_cell_bus rnd_bus  [NumRounds+1];

    // configuration: always accept; unknown indexes cannot occur in one bit
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_KEY_HIGH: r_key_high <= i_cfg.data;
                REG_KEY_LOW:  r_key_low  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // advance the whole chain unless the last stage holds a result not yet taken
    assign adv        = !rnd_bus[NumRounds].vld || o_out.ready;
    assign i_in.ready = adv;

    // input stage: capture the block, the command and the current cipher key
    always_comb begin
        n_in.vld   = i_in.valid;
        n_in.cmd   = t_cmd'(i_in.cmd);
        n_in.key   = {r_key_high, r_key_low};
        n_in.state = {i_in.block_high, i_in.block_low};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else if (adv) begin
            r_in.vld <= n_in.vld;
        end
        if (adv) begin
            r_in.cmd   <= n_in.cmd;
            r_in.state <= n_in.state;
            r_in.key   <= n_in.key;
        end
    end

    assign prep_bus[0] = r_in;

    for (genvar g = 1; g <= NumRounds; g++) begin : g_prep
        aes_key_cell #(.STEP(g)) u_key (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_bus  (prep_bus[g-1]),
            .o_bus  (prep_bus[g])
        );
    end

    // whitening with key zero (encrypt) or key ten (decrypt, now ready)
    assign rnd_bus[0] = '{
        vld:   prep_bus[NumRounds].vld,
        cmd:   prep_bus[NumRounds].cmd,
        state: prep_bus[NumRounds].state ^ prep_bus[NumRounds].key,
        key:   prep_bus[NumRounds].key
    };

    for (genvar g = 1; g <= NumRounds; g++) begin : g_round
        aes_round_cell #(.ROUND(g)) u_round (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (adv),
            .i_bus  (rnd_bus[g-1]),
            .o_bus  (rnd_bus[g])
        );
    end

    assign o_out.valid       = rnd_bus[NumRounds].vld;
    assign o_out.result_high = rnd_bus[NumRounds].state[BlockW-1:HalfW];
    assign o_out.result_low  = rnd_bus[NumRounds].state[HalfW-1:0];
endmodule
`default_nettype wire

FILE: sv/aes_checker.sv
// Checker: port-level properties of the cipher unit, bound to the top level.
`default_nettype none
module aes_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] out_high,
    input wire logic [63:0] out_low
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
        else $error("stalled result changed");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during stall");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result valid after reset");
endmodule

bind aes128_block_cipher_unit aes_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_ready (i_in.ready),
    .out_valid(o_out.valid),
    .out_ready(o_out.ready),
    .out_high (o_out.result_high),
    .out_low  (o_out.result_low)
);
`default_nettype wire
